@@ hdl/smb_pkg.sv @@
package smb_pkg;

  // fixed field widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int CFG_W   = 9;
  localparam int THR_W   = 8;
  localparam int CIDX_W  = 2;

  // frame dimensions and coordinate math, wide enough for 4096 plus the register range
  localparam int DIM_W = 13;

  // default store geometry
  localparam int MAX_COLS_DEF = 256;
  localparam int MAX_ROWS_DEF = 256;

  // register reset values
  localparam logic [THR_W-1:0] THR_RESET   = THR_W'(250);
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(256);

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // store accesses of one mask read, in issue order
  localparam int ACC_W = 3;
  localparam logic [ACC_W-1:0] ACC_CENTER = 3'd0;
  localparam logic [ACC_W-1:0] ACC_UP     = 3'd1;
  localparam logic [ACC_W-1:0] ACC_DOWN   = 3'd2;
  localparam logic [ACC_W-1:0] ACC_LEFT   = 3'd3;
  localparam logic [ACC_W-1:0] ACC_RIGHT  = 3'd4;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_TAIL,
    ST_DONE
  } state_t;

  // frame settings handed to the sequencer
  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } frame_cfg_t;

endpackage

@@ hdl/smb_if.sv @@
interface smb_in_if;
  import smb_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [PIX_W-1:0]   pixel;
  logic               frame_start;

  modport source (output valid, req_type, row, col, pixel, frame_start, input ready);
  modport sink (input valid, req_type, row, col, pixel, frame_start, output ready);
endinterface

interface smb_out_if;
  import smb_pkg::*;

  logic             valid;
  logic             ready;
  logic             mask_bit;
  logic [PIX_W-1:0] frame_peak;

  modport source (output valid, mask_bit, frame_peak, input ready);
  modport sink (input valid, mask_bit, frame_peak, output ready);
endinterface

interface smb_cfg_if;
  import smb_pkg::*;

  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/smb_frame_mem.sv @@
module smb_frame_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/smb_ctrl.sv @@
module smb_ctrl #(
  parameter int MAX_COLS = smb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = smb_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smb_pkg::frame_cfg_t           fcfg,
  smb_in_if.sink                        req,
  smb_out_if.source                     rsp,
  output logic                          mem_we,
  output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] mem_addr,
  output logic [smb_pkg::PIX_W-1:0]     mem_wdata,
  input  logic [smb_pkg::PIX_W-1:0]     mem_rdata
);
  import smb_pkg::*;

  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int ROW_AW = $clog2(MAX_ROWS);

  state_t           state, state_next;
  logic [ACC_W-1:0] cnt, cnt_next;
  logic             hit, hit_next;
  logic             bit_res, bit_res_next;
  logic [DIM_W-1:0] r_q, r_q_next;
  logic [DIM_W-1:0] c_q, c_q_next;
  logic [PIX_W-1:0] peak, peak_next;
  logic             res_valid, res_valid_next;
  logic             res_bit, res_bit_next;
  logic [PIX_W-1:0] res_peak, res_peak_next;

  logic [DIM_W-1:0] in_r, in_c;
  logic             in_inside;
  logic [DIM_W-1:0] up, dn, lf, rt;
  logic [DIM_W-1:0] ar, ac;
  logic             slot_free;

  // incoming coordinates against the frame size
  assign in_r      = DIM_W'(req.row);
  assign in_c      = DIM_W'(req.col);
  assign in_inside = (in_r < fcfg.h) && (in_c < fcfg.w);

  // wrapped neighbors of the held position
  assign up = (r_q == '0) ? fcfg.h - DIM_W'(1) : r_q - DIM_W'(1);
  assign dn = (r_q + DIM_W'(1) >= fcfg.h) ? '0 : r_q + DIM_W'(1);
  assign lf = (c_q == '0) ? fcfg.w - DIM_W'(1) : c_q - DIM_W'(1);
  assign rt = (c_q + DIM_W'(1) >= fcfg.w) ? '0 : c_q + DIM_W'(1);

  // position of the current store access
  always_comb begin
    ar = r_q;
    ac = c_q;
    unique case (cnt)
      ACC_CENTER: begin
        ar = r_q;
        ac = c_q;
      end
      ACC_UP: begin
        ar = up;
      end
      ACC_DOWN: begin
        ar = dn;
      end
      ACC_LEFT: begin
        ac = lf;
      end
      ACC_RIGHT: begin
        ac = rt;
      end
      default: begin
        ar = r_q;
        ac = c_q;
      end
    endcase
  end

  assign slot_free = !res_valid || rsp.ready;

  // sequencer: next state, store port and result register
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    hit_next       = hit;
    bit_res_next   = bit_res;
    r_q_next       = r_q;
    c_q_next       = c_q;
    peak_next      = peak;
    res_valid_next = res_valid && !rsp.ready;
    res_bit_next   = res_bit;
    res_peak_next  = res_peak;
    req.ready      = 1'b0;
    mem_we         = 1'b0;
    mem_addr       = {ar[ROW_AW-1:0], ac[COL_AW-1:0]};
    mem_wdata      = req.pixel;

    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        mem_addr  = {in_r[ROW_AW-1:0], in_c[COL_AW-1:0]};
        if (req.valid) begin
          if (req.req_type == REQ_LOAD) begin
            if (in_inside) begin
              mem_we = 1'b1;
              if (req.frame_start || (req.pixel > peak)) begin
                peak_next = req.pixel;
              end
            end
          end else begin
            r_q_next = in_r;
            c_q_next = in_c;
            cnt_next = ACC_CENTER;
            hit_next = 1'b0;
            if (in_inside && (peak > fcfg.thr)) begin
              state_next = ST_FETCH;
            end else begin
              bit_res_next = 1'b1;
              state_next   = ST_DONE;
            end
          end
        end
      end
      ST_FETCH: begin
        cnt_next = cnt + ACC_W'(1);
        if (cnt == ACC_RIGHT) begin
          state_next = ST_TAIL;
        end
        // data of the previous access is on the read port
        if (cnt == ACC_UP) begin
          if (mem_rdata != peak) begin
            bit_res_next = 1'b1;
            state_next   = ST_DONE;
          end
        end else if (cnt != ACC_CENTER) begin
          hit_next = hit || (mem_rdata == peak);
        end
      end
      ST_TAIL: begin
        bit_res_next = !(hit || (mem_rdata == peak));
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          res_valid_next = 1'b1;
          res_bit_next   = bit_res;
          res_peak_next  = peak;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp.valid      = res_valid;
  assign rsp.mask_bit   = res_bit;
  assign rsp.frame_peak = res_peak;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= ACC_CENTER;
      hit       <= 1'b0;
      peak      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      hit       <= hit_next;
      peak      <= peak_next;
      res_valid <= res_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bit_res  <= bit_res_next;
    r_q      <= r_q_next;
    c_q      <= c_q_next;
    res_bit  <= res_bit_next;
    res_peak <= res_peak_next;
  end

endmodule

@@ hdl/saturation_mask_builder.sv @@
// load: loads are taken back to back while the sequencer is idle
// mask read: ends at once if the pixel is outside or the peak is low, after the center
// access if it is not the peak, else after all five accesses, which share one store port
// a finished result waits in an output register while loads keep being taken
// reset (synchronous) clears the peak, the sequencer and the result register and sets
// the threshold to 250 and both frame sizes to 256; the frame store is not cleared
module saturation_mask_builder #(
  parameter int MAX_COLS = smb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = smb_pkg::MAX_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  smb_in_if.sink    req,
  smb_out_if.source rsp,
  smb_cfg_if.sink   cfg
);
  import smb_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

  logic [THR_W-1:0] thr;
  logic [CFG_W-1:0] width_in_use;
  logic [CFG_W-1:0] height_in_use;
  logic [DIM_W-1:0] wr, hr;
  frame_cfg_t       fcfg;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0]  mem_wdata;
  logic [PIX_W-1:0]  mem_rdata;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr           <= THR_RESET;
      width_in_use  <= WIDTH_RESET;
      height_in_use <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_THRESHOLD: thr <= cfg.data[THR_W-1:0];
        CFG_WIDTH:     width_in_use <= cfg.data;
        CFG_HEIGHT:    height_in_use <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // effective frame size, clamped to 1..max
  assign wr = DIM_W'(width_in_use);
  assign hr = DIM_W'(height_in_use);

  always_comb begin
    fcfg.thr = thr;
    if (wr == '0) begin
      fcfg.w = DIM_W'(1);
    end else if (wr > DIM_W'(MAX_COLS)) begin
      fcfg.w = DIM_W'(MAX_COLS);
    end else begin
      fcfg.w = wr;
    end
    if (hr == '0) begin
      fcfg.h = DIM_W'(1);
    end else if (hr > DIM_W'(MAX_ROWS)) begin
      fcfg.h = DIM_W'(MAX_ROWS);
    end else begin
      fcfg.h = hr;
    end
  end

  smb_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fcfg      (fcfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  smb_frame_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule
